>>> src/cmag_pkg.sv
// cmag_pkg: shared constants for the complex magnitude core.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package cmag_pkg;

   localparam int DEFAULT_SAMPLE_WIDTH = 16;
   localparam int SQUARE_STAGES        = 3;

endpackage

>>> src/cmag_square.sv
// cmag_square: absolute value, squaring and sum of squares, three register stages.
// Depends on cmag_pkg.
`timescale 1ns / 1ps

module cmag_square #(
   parameter int SAMPLE_WIDTH = cmag_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [SAMPLE_WIDTH-1:0]       in_real,
   input  logic [SAMPLE_WIDTH-1:0]       in_imag,
   output logic                          out_valid,
   output logic [2*SAMPLE_WIDTH-1:0]     out_sum
);

   localparam int PW = 2 * SAMPLE_WIDTH;

   logic [2:0]              vld_ff;
   logic [2:0]              vld_in;
   logic [SAMPLE_WIDTH-1:0] abs_re_ff, abs_re_in;
   logic [SAMPLE_WIDTH-1:0] abs_im_ff, abs_im_in;
   logic [PW-1:0]           sq_re_ff, sq_re_in;
   logic [PW-1:0]           sq_im_ff, sq_im_in;
   logic [PW-1:0]           sum_ff, sum_in;

   always_comb begin
      abs_re_in = in_real[SAMPLE_WIDTH-1] ? (~in_real) + 1'b1 : in_real;
      abs_im_in = in_imag[SAMPLE_WIDTH-1] ? (~in_imag) + 1'b1 : in_imag;
      sq_re_in  = PW'(abs_re_ff) * PW'(abs_re_ff);
      sq_im_in  = PW'(abs_im_ff) * PW'(abs_im_ff);
      sum_in    = sq_re_ff + sq_im_ff;
      vld_in    = {vld_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_re_ff <= abs_re_in;
      abs_im_ff <= abs_im_in;
      sq_re_ff  <= sq_re_in;
      sq_im_ff  <= sq_im_in;
      sum_ff    <= sum_in;
   end

   assign out_valid = vld_ff[2];
   assign out_sum   = sum_ff;

endmodule

>>> src/cmag_sqrt.sv
// cmag_sqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on cmag_pkg.
`timescale 1ns / 1ps

module cmag_sqrt #(
   parameter int SAMPLE_WIDTH = cmag_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [2*SAMPLE_WIDTH-1:0]     in_radicand,
   output logic                          out_valid,
   output logic [SAMPLE_WIDTH-1:0]       out_root
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int PW = 2 * W;
   localparam int RW = W + 3;

   logic [W-1:0]  vld_ff, vld_in;
   logic [PW-1:0] rad_ff  [W];
   logic [PW-1:0] rad_in  [W];
   logic [RW-1:0] rem_ff  [W];
   logic [RW-1:0] rem_in  [W];
   logic [W-1:0]  root_ff [W];
   logic [W-1:0]  root_in [W];

   always_comb begin
      logic [PW-1:0] src_rad;
      logic [RW-1:0] src_rem;
      logic [W-1:0]  src_root;
      logic          src_vld;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            src_rad  = in_radicand;
            src_rem  = '0;
            src_root = '0;
            src_vld  = in_valid;
         end else begin
            src_rad  = rad_ff[k-1];
            src_rem  = rem_ff[k-1];
            src_root = root_ff[k-1];
            src_vld  = vld_ff[k-1];
         end
         rem_sh    = {src_rem[RW-3:0], src_rad[PW-1:PW-2]};
         trial     = {1'b0, src_root, 2'b01};
         rad_in[k] = {src_rad[PW-3:0], 2'b00};
         vld_in[k] = src_vld;
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {src_root[W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {src_root[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_valid = vld_ff[W-1];
   assign out_root  = root_ff[W-1];

endmodule

>>> src/complex_magnitude_core.sv
// complex_magnitude_core: floor(sqrt(re^2 + im^2)) of one complex sample per transaction.
// Pipeline: 3 square/sum stages, then one root bit per stage.
// Throughput: one transaction per cycle; busy is high only while reset is asserted.
// Results appear on rsp_valid for one cycle and cannot be stalled by the receiver.
// Reset clears only the valid pipeline; no state survives between transactions.
// Depends on cmag_pkg, cmag_square, cmag_sqrt.
`timescale 1ns / 1ps

module complex_magnitude_core #(
   parameter int SAMPLE_WIDTH = cmag_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0] req_imag_part,
   output logic                           rsp_valid,
   output logic        [SAMPLE_WIDTH-1:0] rsp_magnitude
);

   localparam int PW      = 2 * SAMPLE_WIDTH;
   localparam int LATENCY = cmag_pkg::SQUARE_STAGES + SAMPLE_WIDTH;

   logic          sum_valid;
   logic [PW-1:0] sum;

   assign busy = reset;

   cmag_square #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_real   ($unsigned(req_real_part)),
      .in_imag   ($unsigned(req_imag_part)),
      .out_valid (sum_valid),
      .out_sum   (sum)
   );

   cmag_sqrt #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sum_valid),
      .in_radicand (sum),
      .out_valid   (rsp_valid),
      .out_root    (rsp_magnitude)
   );

   logic [PW+1:0] mag_sq;
   logic [PW+1:0] mag_next_sq;

   assign mag_sq      = (PW+2)'(rsp_magnitude) * (PW+2)'(rsp_magnitude);
   assign mag_next_sq = ((PW+2)'(rsp_magnitude) + 1'b1) * ((PW+2)'(rsp_magnitude) + 1'b1);

   a_result_has_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a transaction");

   a_transaction_has_result: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("transaction lost in pipeline");

   a_root_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mag_sq <= (PW+2)'($past(sum, SAMPLE_WIDTH))) &&
                    (mag_next_sq > (PW+2)'($past(sum, SAMPLE_WIDTH))))
      else $error("magnitude is not the floor root of the sum");

endmodule

>>> tb/cmag_checker.sv
// cmag_checker: watches the request and response channels of complex_magnitude_core.
// Predicts each magnitude, compares it with the returned one and counts mismatches.
// Depends on cmag_pkg for the default sample width.
`timescale 1ns / 1ps

module cmag_checker #(
   parameter int SAMPLE_WIDTH = cmag_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0] req_imag_part,
   input  logic                           rsp_valid,
   input  logic        [SAMPLE_WIDTH-1:0] rsp_magnitude,
   output int                             errors,
   output int                             outstanding,
   output int                             checked
);

   localparam int RING_DEPTH = 64;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] re;
      logic signed [SAMPLE_WIDTH-1:0] im;
      logic        [SAMPLE_WIDTH-1:0] magnitude;
   } magnitude_entry_type;

   magnitude_entry_type expected_ring[RING_DEPTH];
   int                  wr_slot;
   int                  rd_slot;
   int                  pending;

   initial begin
      errors      = 0;
      outstanding = 0;
      checked     = 0;
      wr_slot     = 0;
      rd_slot     = 0;
      pending     = 0;
   end

   // floor(sqrt(re^2 + im^2)), one root bit at a time from the top
   function automatic logic [SAMPLE_WIDTH-1:0] sample_magnitude(
      input logic signed [SAMPLE_WIDTH-1:0] re,
      input logic signed [SAMPLE_WIDTH-1:0] im
   );
      longint            re_wide;
      longint            im_wide;
      longint unsigned   power;
      longint unsigned   root;
      longint unsigned   trial;
      re_wide = re;
      im_wide = im;
      if (re_wide < 0) re_wide = -re_wide;
      if (im_wide < 0) im_wide = -im_wide;
      power = re_wide * re_wide + im_wide * im_wide;
      root  = 0;
      for (int b = SAMPLE_WIDTH - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= power) root = trial;
      end
      return root[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
   endtask

   always @(posedge clock) begin
      magnitude_entry_type entry;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            report_mismatch("rsp_valid is unknown");
         end else if (rsp_valid) begin
            if (pending == 0) begin
               report_mismatch($sformatf("magnitude %0d with no transaction pending",
                                         rsp_magnitude));
            end else begin
               entry   = expected_ring[rd_slot];
               rd_slot = (rd_slot + 1) % RING_DEPTH;
               pending--;
               if (rsp_magnitude !== entry.magnitude)
                  report_mismatch($sformatf("re=%0d im=%0d: magnitude %0d, expected %0d",
                                            entry.re, entry.im, rsp_magnitude,
                                            entry.magnitude));
               checked <= checked + 1;
            end
         end
         if (start && busy === 1'b0) begin
            if (pending == RING_DEPTH) begin
               report_mismatch("too many transactions in flight");
            end else begin
               entry.re               = req_real_part;
               entry.im               = req_imag_part;
               entry.magnitude        = sample_magnitude(req_real_part, req_imag_part);
               expected_ring[wr_slot] = entry;
               wr_slot                = (wr_slot + 1) % RING_DEPTH;
               pending++;
            end
         end
      end
      outstanding <= pending;
   end

endmodule

>>> tb/tb_complex_magnitude_core.sv
// tb_complex_magnitude_core: drives corner and random complex samples in bursts.
// Checking is done by cmag_checker; this top makes stimulus, watches for stalls and gives the verdict.
// Depends on cmag_pkg, complex_magnitude_core and cmag_checker.
`timescale 1ns / 1ps

module tb_complex_magnitude_core;

   localparam int SAMPLE_WIDTH = cmag_pkg::DEFAULT_SAMPLE_WIDTH;
   localparam int LATENCY      = SAMPLE_WIDTH + cmag_pkg::SQUARE_STAGES;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_COUNT = 1050;

   localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           start         = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] req_real_part = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_imag_part = '0;
   logic                           busy;
   logic                           rsp_valid;
   logic        [SAMPLE_WIDTH-1:0] rsp_magnitude;

   int errors;
   int outstanding;
   int checked;
   int sent         = 0;
   int near_squares = 0;
   int stall_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   complex_magnitude_core #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_real_part(req_real_part),
      .req_imag_part(req_imag_part),
      .rsp_valid    (rsp_valid),
      .rsp_magnitude(rsp_magnitude)
   );

   cmag_checker #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_real_part(req_real_part),
      .req_imag_part(req_imag_part),
      .rsp_valid    (rsp_valid),
      .rsp_magnitude(rsp_magnitude),
      .errors       (errors),
      .outstanding  (outstanding),
      .checked      (checked)
   );

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // start stays high into the next transaction unless idle_for or wait_all_returned lowers it
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                              input logic signed [SAMPLE_WIDTH-1:0] im);
      start         <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start         <= 1'b0;
         req_real_part <= SAMPLE_WIDTH'($urandom);
         req_imag_part <= SAMPLE_WIDTH'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_all_returned();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic pick_pair(output logic signed [SAMPLE_WIDTH-1:0] re,
                            output logic signed [SAMPLE_WIDTH-1:0] im);
      logic signed [SAMPLE_WIDTH-1:0] corners[7];
      int                             leg_a[4];
      int                             leg_b[4];
      int                             t;
      longint                         k;
      longint                         a_val;
      longint                         b_val;
      corners = '{MOST_NEG, SAMPLE_WIDTH'(MOST_NEG + 1), -1, 0, 1,
                  SAMPLE_WIDTH'(MOST_POS - 1), MOST_POS};
      leg_a   = '{3, 5, 8, 7};
      leg_b   = '{4, 12, 15, 24};
      case ($urandom_range(0, 9))
         0: begin
            re = corners[$urandom_range(0, 6)];
            im = corners[$urandom_range(0, 6)];
         end
         1: begin
            re = SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
            im = SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
         end
         2, 3: begin
            // right triangles: sum of squares lands on or near a perfect square
            t     = $urandom_range(0, 3);
            k     = $urandom_range(1, (2 ** (SAMPLE_WIDTH - 1) - 2) / 25);
            a_val = leg_a[t] * k + $urandom_range(0, 2) - 1;
            b_val = leg_b[t] * k + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) a_val = -a_val;
            if ($urandom_range(0, 1)) b_val = -b_val;
            re = SAMPLE_WIDTH'(a_val);
            im = SAMPLE_WIDTH'(b_val);
            near_squares++;
         end
         default: begin
            re = SAMPLE_WIDTH'($urandom);
            im = SAMPLE_WIDTH'($urandom);
         end
      endcase
   endtask

   initial begin
      logic signed [SAMPLE_WIDTH-1:0] re;
      logic signed [SAMPLE_WIDTH-1:0] im;
      int                             burst;
      int                             done;
      bit                             drained_mid;

      done        = 0;
      drained_mid = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_sample(0, 0);
      send_sample(MOST_NEG, MOST_NEG);
      send_sample(MOST_POS, MOST_POS);
      send_sample(MOST_NEG, MOST_POS);
      send_sample(MOST_POS, MOST_NEG);
      send_sample(MOST_NEG, 0);
      send_sample(0, MOST_NEG);
      send_sample(MOST_POS, 0);
      send_sample(0, MOST_POS);
      send_sample(1, 0);
      send_sample(-1, -1);
      send_sample(3, -4);
      send_sample(-3, 4);
      send_sample(2, 2);
      send_sample(24, 7);
      send_sample(SAMPLE_WIDTH'(MOST_NEG + 1), MOST_NEG);
      send_sample(16'sh5555, -16'sh2AAB);
      wait_all_returned();

      while (done < RANDOM_COUNT) begin
         burst = $urandom_range(1, 32);
         for (int i = 0; i < burst && done < RANDOM_COUNT; i++) begin
            pick_pair(re, im);
            send_sample(re, im);
            done++;
         end
         if (!drained_mid && done >= RANDOM_COUNT / 2) begin
            drained_mid = 1;
            wait_all_returned();
         end else if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 10));
         end
      end

      wait_all_returned();
      repeat (LATENCY + 5) @(posedge clock);

      $display("Sent %0d samples (corners, %0d near perfect squares, random), %0d checked.",
               sent, near_squares, checked);
      $display("Bursts with random gaps, back-to-back runs and full pipeline drains.");
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
